// ----- rtl/core/brm_pkg.sv -----
// Package for the banked ROM mapper: field widths, target codes, register offsets
// and the structs passed between the translate logic and the mapper registers.
// Has no dependencies.
package brm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int MEM_ADDR_W  = 22;
    localparam int BANK_OFS_W  = 14;
    localparam int WRAM_ADDR_W = 13;  // 8 KB work RAM

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_WRAM = 2'd1,
        TGT_SRAM = 2'd2,
        TGT_NONE = 2'd3
    } t_target;

    // 16 KB region selected by address bits 15:14.
    localparam logic [1:0] REGION_FRAME0 = 2'd0;
    localparam logic [1:0] REGION_FRAME1 = 2'd1;
    localparam logic [1:0] REGION_FRAME2 = 2'd2;
    localparam logic [1:0] REGION_WRAM   = 2'd3;

    // Mapper registers live at FFF8-FFFF.
    localparam logic [12:0] REG_WINDOW_HI = 13'h1FFF;
    localparam logic [2:0]  OFS_CONTROL   = 3'd4;
    localparam logic [2:0]  OFS_FRAME0    = 3'd5;
    localparam logic [2:0]  OFS_FRAME1    = 3'd6;
    localparam logic [2:0]  OFS_FRAME2    = 3'd7;

    // Frame 0 keeps its first 1 KB in bank 0: address bits 15:10 all zero.
    localparam logic [5:0]  FIXED_KB_HI   = 6'd0;

    localparam int SRAM_ON_BIT   = 3;
    localparam int SRAM_BANK_BIT = 2;

    localparam logic [DATA_W-1:0] FRAME0_RESET = 8'd0;
    localparam logic [DATA_W-1:0] FRAME1_RESET = 8'd1;
    localparam logic [DATA_W-1:0] FRAME2_RESET = 8'd2;
    localparam logic [DATA_W-1:0] MASK_RESET   = 8'hFF;

    typedef enum logic [2:0] {
        REG_GLASSES,
        REG_CONTROL,
        REG_FRAME0,
        REG_FRAME1,
        REG_FRAME2
    } t_reg_sel;

    typedef struct packed {
        logic                    operation;
        logic [ADDR_W-1:0]       address;
        logic [DATA_W-1:0]       write_data;
    } t_item;

    typedef struct packed {
        t_target                 target;
        logic [MEM_ADDR_W-1:0]   memory_address;
        logic                    write_enable;
        logic [DATA_W-1:0]       store_data;
    } t_result;

    typedef struct packed {
        logic [DATA_W-1:0]       frame0_bank;
        logic [DATA_W-1:0]       frame1_bank;
        logic [DATA_W-1:0]       frame2_bank;
        logic [DATA_W-1:0]       save_ram_control;
        logic [DATA_W-1:0]       glasses_latch;
    } t_regs;

    typedef struct packed {
        logic                    en;
        t_reg_sel                sel;
        logic [DATA_W-1:0]       value;
    } t_reg_wr;

endpackage

// ----- rtl/core/brm_regs.sv -----
// Mapper register file: frame banks, save RAM control and glasses latch.
// Depends on brm_pkg for the register and write-request structs.
module brm_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brm_pkg::t_reg_wr i_wr,
    output brm_pkg::t_regs   o_regs
);
    import brm_pkg::*;

    t_regs r_regs;
    t_regs n_regs;

    always_comb begin
        n_regs = r_regs;
        if (i_wr.en) begin
            case (i_wr.sel)
                REG_CONTROL: n_regs.save_ram_control = i_wr.value;
                REG_FRAME0:  n_regs.frame0_bank      = i_wr.value;
                REG_FRAME1:  n_regs.frame1_bank      = i_wr.value;
                REG_FRAME2:  n_regs.frame2_bank      = i_wr.value;
                default:     n_regs.glasses_latch    = i_wr.value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.frame0_bank      <= FRAME0_RESET;
            r_regs.frame1_bank      <= FRAME1_RESET;
            r_regs.frame2_bank      <= FRAME2_RESET;
            r_regs.save_ram_control <= '0;
            r_regs.glasses_latch    <= '0;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

// ----- rtl/core/brm_translate.sv -----
// Address translation for one CPU access: picks the target memory, forms the
// byte address and decodes mapper register writes. Depends on brm_pkg.
module brm_translate #(
    parameter int ROM_ADDR_BITS = 22
) (
    input  brm_pkg::t_item            i_item,
    input  brm_pkg::t_regs            i_regs,
    input  logic [brm_pkg::DATA_W-1:0] i_bank_mask,
    output brm_pkg::t_result          o_result,
    output brm_pkg::t_reg_wr          o_reg_wr
);
    import brm_pkg::*;

    localparam logic [MEM_ADDR_W-1:0] RomMask =
        MEM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    logic [1:0]            region;
    logic [BANK_OFS_W-1:0] ofs;
    logic [MEM_ADDR_W-1:0] wram_addr;
    logic [MEM_ADDR_W-1:0] sram_addr;
    logic [MEM_ADDR_W-1:0] rom0_addr;
    logic [MEM_ADDR_W-1:0] rom1_addr;
    logic [MEM_ADDR_W-1:0] rom2_addr;
    logic                  sram_on;
    logic                  reg_hit;
    logic [DATA_W-1:0]     masked;

    assign region    = i_item.address[ADDR_W-1 -: 2];
    assign ofs       = i_item.address[BANK_OFS_W-1:0];
    assign wram_addr = MEM_ADDR_W'(i_item.address[WRAM_ADDR_W-1:0]);
    assign sram_on   = i_regs.save_ram_control[SRAM_ON_BIT];
    assign sram_addr = MEM_ADDR_W'({i_regs.save_ram_control[SRAM_BANK_BIT], ofs});
    assign rom0_addr = (i_item.address[ADDR_W-1:10] == FIXED_KB_HI)
                     ? MEM_ADDR_W'(i_item.address)
                     : ({i_regs.frame0_bank, ofs} & RomMask);
    assign rom1_addr = {i_regs.frame1_bank, ofs} & RomMask;
    assign rom2_addr = {i_regs.frame2_bank, ofs} & RomMask;
    assign reg_hit   = i_item.address[ADDR_W-1:3] == REG_WINDOW_HI;
    assign masked    = i_item.write_data & i_bank_mask;

    always_comb begin
        o_result = '{target: TGT_NONE, memory_address: '0, write_enable: 1'b0,
                     store_data: '0};
        o_reg_wr = '{en: 1'b0, sel: REG_GLASSES, value: i_item.write_data};

        if (!i_item.operation) begin
            case (region)
                REGION_FRAME0: begin
                    o_result.target         = TGT_ROM;
                    o_result.memory_address = rom0_addr;
                end
                REGION_FRAME1: begin
                    o_result.target         = TGT_ROM;
                    o_result.memory_address = rom1_addr;
                end
                REGION_FRAME2: begin
                    o_result.target         = sram_on ? TGT_SRAM : TGT_ROM;
                    o_result.memory_address = sram_on ? sram_addr : rom2_addr;
                end
                default: begin
                    o_result.target         = TGT_WRAM;
                    o_result.memory_address = wram_addr;
                end
            endcase
        end else if (reg_hit) begin
            // Register writes also land in work RAM with the stored value.
            o_reg_wr.en = 1'b1;
            case (i_item.address[2:0])
                OFS_CONTROL: o_reg_wr.sel = REG_CONTROL;
                OFS_FRAME0: begin
                    o_reg_wr.sel   = REG_FRAME0;
                    o_reg_wr.value = masked;
                end
                OFS_FRAME1: begin
                    o_reg_wr.sel   = REG_FRAME1;
                    o_reg_wr.value = masked;
                end
                OFS_FRAME2: begin
                    o_reg_wr.sel   = REG_FRAME2;
                    o_reg_wr.value = masked;
                end
                default:     o_reg_wr.sel = REG_GLASSES;
            endcase
            o_result.target         = TGT_WRAM;
            o_result.memory_address = wram_addr;
            o_result.write_enable   = 1'b1;
            o_result.store_data     = o_reg_wr.value;
        end else if (region == REGION_WRAM) begin
            o_result.target         = TGT_WRAM;
            o_result.memory_address = wram_addr;
            o_result.write_enable   = 1'b1;
            o_result.store_data     = i_item.write_data;
        end else if (region == REGION_FRAME2 && sram_on) begin
            o_result.target         = TGT_SRAM;
            o_result.memory_address = sram_addr;
            o_result.write_enable   = 1'b1;
            o_result.store_data     = i_item.write_data;
        end
    end

endmodule

// ----- rtl/core/banked_rom_mapper_with_save_ram.sv -----
// Top level of the banked ROM mapper with save RAM: input register, translate
// logic, mapper registers and result register. Depends on brm_pkg,
// brm_translate and brm_regs.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   -------------------------------------------
//   in        i_in_valid / o_in_ready      i_operation, i_address, i_write_data
//   out       o_out_valid / i_out_ready    o_target, o_memory_address,
//                                          o_write_enable, o_store_data
//   cfg       i_rom_bank_mask_we           i_rom_bank_mask
//
// An access is captured in the input register and then translated into the result
// register, which it leaves on an out transfer; one access is taken every cycle while
// the result is not held by i_out_ready. Mapper registers update when an access moves
// into the result register, so the next access sees them at once. When the result
// waits, the input register still takes one more access. Synchronous active-low reset
// clears the valid flags and mapper registers, but sets frame banks 1 and 2 to 1 and 2.
module banked_rom_mapper_with_save_ram #(
    parameter int ROM_ADDR_BITS = 22
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rom_bank_mask_we,
    input  logic [brm_pkg::DATA_W-1:0]        i_rom_bank_mask,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [brm_pkg::ADDR_W-1:0]        i_address,
    input  logic [brm_pkg::DATA_W-1:0]        i_write_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_target,
    output logic [brm_pkg::MEM_ADDR_W-1:0]    o_memory_address,
    output logic                              o_write_enable,
    output logic [brm_pkg::DATA_W-1:0]        o_store_data
);
    import brm_pkg::*;

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_result;
    logic [DATA_W-1:0] r_rom_bank_mask;

    logic    w_advance;
    t_result w_result;
    t_reg_wr w_reg_wr;
    t_reg_wr w_reg_commit;
    t_regs   w_regs;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank_mask <= MASK_RESET;
        end else if (i_rom_bank_mask_we) begin
            r_rom_bank_mask <= i_rom_bank_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{operation: i_operation, address: i_address,
                        write_data: i_write_data};
        end
    end

    brm_translate #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_translate (
        .i_item      (r_item),
        .i_regs      (w_regs),
        .i_bank_mask (r_rom_bank_mask),
        .o_result    (w_result),
        .o_reg_wr    (w_reg_wr)
    );

    // A register write takes effect only on the cycle its access moves on.
    always_comb begin
        w_reg_commit    = w_reg_wr;
        w_reg_commit.en = w_reg_wr.en && w_advance;
    end

    brm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_reg_commit),
        .o_regs  (w_regs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_result.target;
    assign o_memory_address = r_result.memory_address;
    assign o_write_enable   = r_result.write_enable;
    assign o_store_data     = r_result.store_data;

    a_drop_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target == TGT_NONE
        |-> o_memory_address == '0 && !o_write_enable && o_store_data == '0)
        else $error("dropped write carries nonzero fields");

    a_sram_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target == TGT_SRAM
        |-> o_memory_address[MEM_ADDR_W-1:BANK_OFS_W+1] == '0)
        else $error("save RAM address beyond 32 KB");

    a_frame1_masked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_reg_commit.en) && $past(w_reg_commit.sel) == REG_FRAME1
        |-> w_regs.frame1_bank == $past(w_reg_commit.value)
            && (w_regs.frame1_bank & ~$past(r_rom_bank_mask)) == '0)
        else $error("frame 1 bank not loaded with masked value");

    a_reg_write_hits_wram : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reg_commit.en |=> o_out_valid && o_target == TGT_WRAM && o_write_enable
            && o_store_data == $past(w_reg_commit.value))
        else $error("register write not mirrored into work RAM");

endmodule
